// File: rtl/core/phni_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phni_pkg
// Types, constants and the hazard classification shared by the NOP inserter.
// ----------------------------------------------------------------------------
package phni_pkg;

    localparam logic [31:0] NOP_WORD   = 32'h0000_0013;
    localparam logic [6:0]  OP_BRANCH  = 7'b1100011;
    localparam logic [6:0]  OP_STORE   = 7'b0100011;
    localparam logic [6:0]  OP_LOAD    = 7'b0000011;
    localparam logic        MODE_STALL = 1'b0;
    localparam logic        MODE_FWD   = 1'b1;
    localparam int          BATCH_MAX  = 3;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W     = $clog2(QUEUE_DEPTH);

    // Everything one accepted word releases: up to three instructions, each
    // with the number of NOPs that must follow it.
    typedef struct packed {
        logic [BATCH_MAX-1:0][31:0] words;
        logic [BATCH_MAX-1:0][1:0]  nops;
        logic [1:0]                 cnt_m1;
    } t_batch;

    function automatic logic [1:0] nop_count(
        input logic [31:0] cur,
        input logic        has1,
        input logic [31:0] n1,
        input logic        has2,
        input logic [31:0] n2,
        input logic        mode
    );
        logic [6:0] op;
        logic [4:0] rd;
        logic       hit1;
        logic       hit2;
        logic [1:0] res;
        op   = cur[6:0];
        rd   = cur[11:7];
        hit1 = has1 && ((n1[19:15] == rd) || (n1[24:20] == rd));
        hit2 = has2 && ((n2[19:15] == rd) || (n2[24:20] == rd));
        if (mode != MODE_FWD) begin
            if ((op == OP_BRANCH) || (op == OP_STORE)) begin
                res = 2'd0;
            end else begin
                res = {hit1, hit2};
            end
        end else if (op != OP_LOAD) begin
            res = 2'd0;
        end else if (hit1) begin
            res = 2'd2;
        end else begin
            res = {1'b0, hit2};
        end
        return res;
    endfunction

endpackage

// File: rtl/core/pipeline_hazard_nop_inserter_unit.sv
`timescale 1ns / 1ps
// The first result of a batch is held in the batch queue and then in the
// registered output stage before it reaches the output.
// Throughput: one result word per cycle while i_ready is high; a word releases
// 0 to 8 results. Input is taken every cycle while the four-entry batch queue
// has room.
// Reset (synchronous, active low) empties the window and queue, mode to 0.
// ----------------------------------------------------------------------------
// pipeline_hazard_nop_inserter_unit
// Inserts NOP words after RISC-V instructions whose destination register is
// read by one of the next two instructions (in forwarding mode, only loads).
// ----------------------------------------------------------------------------
module pipeline_hazard_nop_inserter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instruction,
    input  logic        i_program_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_word,
    output logic        o_inserted_nop,
    output logic        o_run_last
);

    logic             r_hazard_mode;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    phni_pkg::t_batch batch;
    phni_pkg::t_batch head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hazard_mode <= phni_pkg::MODE_STALL;
        end else if (i_cfg_we) begin
            r_hazard_mode <= i_cfg_wdata;
        end
    end

    phni_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_instruction (i_instruction),
        .i_program_end (i_program_end),
        .i_mode        (r_hazard_mode),
        .i_full        (full),
        .o_push        (push),
        .o_batch       (batch)
    );

    phni_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_batch (batch),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    phni_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_word         (o_word),
        .o_inserted_nop (o_inserted_nop),
        .o_run_last     (o_run_last)
    );

endmodule

// File: rtl/core/phni_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phni_front
// Look-ahead window: accepts words and forms the batch of instructions and
// NOP counts that each word releases.
// ----------------------------------------------------------------------------
module phni_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_instruction,
    input  logic               i_program_end,
    input  logic               i_mode,
    input  logic               i_full,
    output logic               o_push,
    output phni_pkg::t_batch   o_batch
);

    logic [1:0][31:0] r_win;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             accept;
    logic [2:0][31:0] seq;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        seq[0] = (r_count == 2'd0) ? i_instruction : r_win[0];
        seq[1] = (r_count == 2'd1) ? i_instruction : r_win[1];
        seq[2] = i_instruction;
    end

    always_comb begin
        o_batch.words  = seq;
        o_batch.nops[0] = phni_pkg::nop_count(seq[0], r_count >= 2'd1, seq[1],
                                               r_count >= 2'd2, seq[2], i_mode);
        o_batch.nops[1] = phni_pkg::nop_count(seq[1], r_count >= 2'd2, seq[2],
                                               1'b0, 32'd0, i_mode);
        o_batch.nops[2] = 2'd0;
        o_batch.cnt_m1  = i_program_end ? r_count : 2'd0;
        o_push          = accept && (i_program_end || (r_count == 2'd2));
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_program_end) begin
                n_count = 2'd0;
            end else if (r_count != 2'd2) begin
                n_count = r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_program_end) begin
            if (r_count == 2'd2) begin
                r_win[0] <= r_win[1];
                r_win[1] <= i_instruction;
            end else begin
                r_win[r_count[0]] <= i_instruction;
            end
        end
    end

endmodule

// File: rtl/core/phni_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phni_queue
// Short first-in first-out queue of batches between the window and the
// output sequencer.
// ----------------------------------------------------------------------------
module phni_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  phni_pkg::t_batch   i_batch,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output phni_pkg::t_batch   o_head
);

    phni_pkg::t_batch             r_mem [phni_pkg::QUEUE_DEPTH];
    logic [phni_pkg::QPTR_W:0]    r_wr_ptr;
    logic [phni_pkg::QPTR_W:0]    r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[phni_pkg::QPTR_W] != r_rd_ptr[phni_pkg::QPTR_W]) &&
                     (r_wr_ptr[phni_pkg::QPTR_W-1:0] == r_rd_ptr[phni_pkg::QPTR_W-1:0]);
    assign o_head  = r_mem[r_rd_ptr[phni_pkg::QPTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[phni_pkg::QPTR_W-1:0]] <= i_batch;
        end
    end

endmodule

// File: rtl/core/phni_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phni_back
// Output sequencer: expands each batch into instruction and NOP words, one
// per cycle while the output is taken, through a registered output stage.
// ----------------------------------------------------------------------------
module phni_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  phni_pkg::t_batch   i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_word,
    output logic               o_inserted_nop,
    output logic               o_run_last
);

    logic        r_valid;
    logic [31:0] r_word;
    logic        r_nop;
    logic        r_last;
    logic [1:0]  r_idx;
    logic [1:0]  r_sub;
    logic        load;
    logic        step;
    logic        instr_done;
    logic        batch_done;

    assign load       = !r_valid || i_ready;
    assign step       = load && !i_empty;
    assign instr_done = (r_sub == i_head.nops[r_idx]);
    assign batch_done = instr_done && (r_idx == i_head.cnt_m1);
    assign o_pop      = step && batch_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_sub   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (step) begin
                if (batch_done) begin
                    r_idx <= 2'd0;
                    r_sub <= 2'd0;
                end else if (instr_done) begin
                    r_idx <= r_idx + 2'd1;
                    r_sub <= 2'd0;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_word <= (r_sub == 2'd0) ? i_head.words[r_idx] : phni_pkg::NOP_WORD;
            r_nop  <= (r_sub != 2'd0);
            r_last <= batch_done;
        end
    end

    assign o_valid        = r_valid;
    assign o_word         = r_word;
    assign o_inserted_nop = r_nop;
    assign o_run_last     = r_last;

endmodule
